/* rtl/dsse_pkg.sv */
// ----------------------------------------------------------------------------
// dsse_pkg
// Shared types, sizes and the segment code table for the decimal
// seven-segment encoder.
// ----------------------------------------------------------------------------
package dsse_pkg;

    localparam int BIN_W           = 32;
    localparam int BCD_DIGITS      = 10;             // decimal digits of a 32-bit value
    localparam int BCD_W           = 4 * BCD_DIGITS;
    localparam int FIELD_COUNT     = 8;
    localparam int SEG_W           = 8;
    localparam int STEPS_PER_STAGE = 8;
    localparam int DABBLE_STAGES   = BIN_W / STEPS_PER_STAGE;
    localparam int LATENCY         = DABBLE_STAGES + 1;
    localparam int DIGIT_COUNT_DEF = 8;

    localparam logic [SEG_W-1:0] SEG_BLANK = 8'hFF;

    typedef struct packed {
        logic             valid;
        logic [BCD_W-1:0] bcd;
        logic [BIN_W-1:0] bin;
    } dabble_t;

    // Active-low common-anode codes, decimal point off.
    function automatic logic [SEG_W-1:0] seg_code(input logic [3:0] digit);
        logic [SEG_W-1:0] code;
        unique case (digit)
            4'd0:    code = 8'hC0;
            4'd1:    code = 8'hF9;
            4'd2:    code = 8'hA4;
            4'd3:    code = 8'hB0;
            4'd4:    code = 8'h99;
            4'd5:    code = 8'h92;
            4'd6:    code = 8'h82;
            4'd7:    code = 8'hF8;
            4'd8:    code = 8'h80;
            4'd9:    code = 8'h90;
            default: code = SEG_BLANK;
        endcase
        return code;
    endfunction

endpackage

/* rtl/dsse_dabble_stage.sv */
// ----------------------------------------------------------------------------
// dsse_dabble_stage
// One registered slice of the binary-to-BCD conversion: a fixed number of
// add-3-and-shift steps, with the valid bit carried alongside.
// ----------------------------------------------------------------------------
module dsse_dabble_stage (
    input  logic             clk,
    input  logic             rst_n,
    input  dsse_pkg::dabble_t stage_in,
    output dsse_pkg::dabble_t stage_out
);

    logic [dsse_pkg::BCD_W-1:0] bcd_next;
    logic [dsse_pkg::BIN_W-1:0] bin_next;
    logic                       valid_reg;
    logic [dsse_pkg::BCD_W-1:0] bcd_reg;
    logic [dsse_pkg::BIN_W-1:0] bin_reg;

    always_comb
    begin
        bcd_next = stage_in.bcd;
        bin_next = stage_in.bin;
        for (int s = 0; s < dsse_pkg::STEPS_PER_STAGE; s++)
        begin
            for (int d = 0; d < dsse_pkg::BCD_DIGITS; d++)
            begin
                if (bcd_next[4*d +: 4] >= 4'd5)
                begin
                    bcd_next[4*d +: 4] = bcd_next[4*d +: 4] + 4'd3;
                end
            end
            bcd_next = {bcd_next[dsse_pkg::BCD_W-2:0], bin_next[dsse_pkg::BIN_W-1]};
            bin_next = {bin_next[dsse_pkg::BIN_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= stage_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        bcd_reg <= bcd_next;
        bin_reg <= bin_next;
    end

    assign stage_out.valid = valid_reg;
    assign stage_out.bcd   = bcd_reg;
    assign stage_out.bin   = bin_reg;

endmodule

/* rtl/decimal_seven_segment_encoder.sv */
// ----------------------------------------------------------------------------
// decimal_seven_segment_encoder
// Shows a 32-bit unsigned value as eight active-low seven-segment codes.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with value for one cycle to launch a transaction; busy is
//   always low, so a new value may be given in every cycle.
//   The result appears on seg_digit_0..seg_digit_7 with done high for
//   exactly one cycle, after the four slice registers and the output register.
//   Throughput is one transaction per cycle. The binary-to-BCD conversion
//   runs as four registered slices of eight shift-add steps each, followed
//   by one register for digit blanking and segment lookup.
//   seg_digit_0 is the leftmost digit, seg_digit_7 the units digit. Only
//   the lowest DIGIT_COUNT decimal digits are shown; leading zeros, and
//   a value of zero, show blank (FF).
//   Reset clears all valid bits, so no result comes out of a transaction
//   in flight at reset. The receiver cannot stall: results are not held.
// ----------------------------------------------------------------------------
module decimal_seven_segment_encoder #(
    parameter int DIGIT_COUNT = dsse_pkg::DIGIT_COUNT_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [dsse_pkg::BIN_W-1:0] value,
    output logic                       done,
    output logic [dsse_pkg::SEG_W-1:0] seg_digit_0,
    output logic [dsse_pkg::SEG_W-1:0] seg_digit_1,
    output logic [dsse_pkg::SEG_W-1:0] seg_digit_2,
    output logic [dsse_pkg::SEG_W-1:0] seg_digit_3,
    output logic [dsse_pkg::SEG_W-1:0] seg_digit_4,
    output logic [dsse_pkg::SEG_W-1:0] seg_digit_5,
    output logic [dsse_pkg::SEG_W-1:0] seg_digit_6,
    output logic [dsse_pkg::SEG_W-1:0] seg_digit_7
);

    dsse_pkg::dabble_t stage_q [0:dsse_pkg::DABBLE_STAGES];

    logic [dsse_pkg::BCD_DIGITS-1:0] any_hi;
    logic [dsse_pkg::SEG_W-1:0]      seg_next [0:dsse_pkg::FIELD_COUNT-1];
    logic [dsse_pkg::SEG_W-1:0]      seg_reg  [0:dsse_pkg::FIELD_COUNT-1];
    logic                            done_reg;
    logic [dsse_pkg::BCD_W-1:0]      bcd_final;

    assign busy = 1'b0;

    assign stage_q[0].valid = start && !busy;
    assign stage_q[0].bcd   = '0;
    assign stage_q[0].bin   = value;

    for (genvar g = 0; g < dsse_pkg::DABBLE_STAGES; g++)
    begin : g_dabble
        dsse_dabble_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .stage_in  (stage_q[g]),
            .stage_out (stage_q[g+1])
        );
    end

    assign bcd_final = stage_q[dsse_pkg::DABBLE_STAGES].bcd;

    // A position is lit when it or any higher kept digit is nonzero;
    // digits at or above DIGIT_COUNT are dropped (modulo 10^DIGIT_COUNT).
    always_comb
    begin
        logic any;
        any = 1'b0;
        for (int k = dsse_pkg::BCD_DIGITS - 1; k >= 0; k--)
        begin
            if (k < DIGIT_COUNT && bcd_final[4*k +: 4] != 4'd0)
            begin
                any = 1'b1;
            end
            any_hi[k] = any;
        end
    end

    always_comb
    begin
        for (int p = 0; p < dsse_pkg::FIELD_COUNT; p++)
        begin
            if (p < DIGIT_COUNT && any_hi[p])
            begin
                seg_next[dsse_pkg::FIELD_COUNT-1-p] = dsse_pkg::seg_code(bcd_final[4*p +: 4]);
            end
            else
            begin
                seg_next[dsse_pkg::FIELD_COUNT-1-p] = dsse_pkg::SEG_BLANK;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= stage_q[dsse_pkg::DABBLE_STAGES].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        seg_reg <= seg_next;
    end

    assign done        = done_reg;
    assign seg_digit_0 = seg_reg[0];
    assign seg_digit_1 = seg_reg[1];
    assign seg_digit_2 = seg_reg[2];
    assign seg_digit_3 = seg_reg[3];
    assign seg_digit_4 = seg_reg[4];
    assign seg_digit_5 = seg_reg[5];
    assign seg_digit_6 = seg_reg[6];
    assign seg_digit_7 = seg_reg[7];

endmodule

/* rtl/dsse_checker.sv */
// ----------------------------------------------------------------------------
// dsse_checker
// Port-level checks on transaction timing and blanking of the encoder.
// ----------------------------------------------------------------------------
module dsse_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       start,
    input logic                       busy,
    input logic [dsse_pkg::BIN_W-1:0] value,
    input logic                       done,
    input logic [dsse_pkg::SEG_W-1:0] seg_digit_0,
    input logic [dsse_pkg::SEG_W-1:0] seg_digit_7
);

    // every accepted transaction yields its result after the fixed latency
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##(dsse_pkg::LATENCY) done)
        else $error("result missing after accepted transaction");

    // no result without a transaction accepted that many cycles earlier
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, dsse_pkg::LATENCY))
        else $error("result without matching transaction");

    // zero blanks the display, checked on the leftmost and the units digit
    a_zero_blank: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && value == '0) |-> ##(dsse_pkg::LATENCY)
            (seg_digit_7 == dsse_pkg::SEG_BLANK && seg_digit_0 == dsse_pkg::SEG_BLANK))
        else $error("zero value not blanked");

    // a nonzero value below ten shows its units digit
    a_units_lit: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && value != '0 && value < 10) |-> ##(dsse_pkg::LATENCY)
            (seg_digit_7 != dsse_pkg::SEG_BLANK))
        else $error("units digit blanked for nonzero value");

endmodule

bind decimal_seven_segment_encoder dsse_checker u_dsse_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .value       (value),
    .done        (done),
    .seg_digit_0 (seg_digit_0),
    .seg_digit_7 (seg_digit_7)
);
